>>> hw/rtl/tpa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the page allocator.
`timescale 1ns / 1ps

package tpa_pkg;

    localparam int PAGE_BITS = 10;
    localparam int REF_BITS  = 16;

    localparam int LEAVES = 1 << PAGE_BITS;
    localparam int INNER  = LEAVES - 1;
    localparam int HALF   = LEAVES / 2;
    localparam int FC_W   = PAGE_BITS + 1;
    localparam int LVL_W  = $clog2(PAGE_BITS + 1);
    localparam int BOTTOM = PAGE_BITS - 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_ADDREF  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_UNREF = 2'd2,
        ST_SAT   = 2'd3
    } st_t;

    typedef struct packed {
        logic clear;
        logic take;
        logic down_first;
        logic down_next;
        logic leaf;
        logic res_full;
        logic res_unref;
        logic res_sat;
        logic add_inc;
        logic rel_dec;
        logic up_start;
        logic up_step;
        logic echo;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_done;
        logic root_zero;
        logic ref_zero;
        logic ref_max;
        logic ref_one;
        logic en_bottom;
        logic cur_root;
    } dp_stat_t;

endpackage

>>> hw/rtl/tree_page_allocator_refcount.sv
// Top level of the binary-tree page allocator with per-page reference counts.
`timescale 1ns / 1ps

// Page allocator over 1024 pages. Internal tree nodes keep the number of free
// pages beneath them, in a 1023 x 11 memory; each page keeps a 16-bit reference
// count in a 1024 x 16 memory. After reset the block runs a clearing pass that
// loads both memories (s_ready stays low meanwhile). Each command is one
// transfer in and exactly one transfer out. Allocate walks the tree from the
// root, one level per cycle through the free-count memory; allocate on a full
// tree answers with status 1 without walking it. A release whose count drops to
// zero also bumps the free counts of all ten ancestors, one per cycle. The walks
// use the one read port and the one write port of the free-count memory; one
// command is in flight at a time. A result sits in an output register, so the
// next command transfer is taken while the previous result waits for m_ready.
// Status codes: 0 ok, 1 memory full, 2 page not referenced, 3 count saturated.

module tree_page_allocator_refcount import tpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [PAGE_BITS-1:0] s_page,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PAGE_BITS-1:0] m_page_out,
    output logic [REF_BITS-1:0]  m_ref_count,
    output logic [1:0]           m_status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: owns the handshakes and steps the datapath
    tpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories, walk registers and the result/output registers
    tpa_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_cmd),
        .in_page    (s_page),
        .out_page   (m_page_out),
        .out_count  (m_ref_count),
        .out_status (m_status)
    );

endmodule

>>> hw/rtl/tpa_ctrl.sv
// Sequencer for the page allocator: clear pass, command decode, tree walks, result handoff.
`timescale 1ns / 1ps

module tpa_ctrl import tpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FETCH,
        S_DOWN,
        S_LEAF,
        S_UP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.clear = 1'b1;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                unique case (stat.op)
                    OP_ALLOC: begin
                        if (stat.root_zero) begin
                            cmd.res_full = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            cmd.down_first = 1'b1;
                            state_next     = stat.en_bottom ? S_LEAF : S_DOWN;
                        end
                    end
                    OP_ADDREF: begin
                        if (stat.ref_zero) begin
                            cmd.res_unref = 1'b1;
                        end else if (stat.ref_max) begin
                            cmd.res_sat = 1'b1;
                        end else begin
                            cmd.add_inc = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    OP_RELEASE: begin
                        if (stat.ref_zero) begin
                            cmd.res_unref = 1'b1;
                            state_next    = S_DONE;
                        end else if (stat.ref_one) begin
                            cmd.rel_dec  = 1'b1;
                            cmd.up_start = 1'b1;
                            state_next   = S_UP;
                        end else begin
                            cmd.rel_dec = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                    default: begin
                        cmd.echo   = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DOWN: begin
                cmd.down_next = 1'b1;
                state_next    = stat.en_bottom ? S_LEAF : S_DOWN;
            end
            S_LEAF: begin
                cmd.leaf   = 1'b1;
                state_next = S_DONE;
            end
            S_UP: begin
                cmd.up_step = 1'b1;
                if (stat.cur_root) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hw/rtl/tpa_dpath.sv
// Datapath for the page allocator: free-count and reference-count memories, walk registers.
`timescale 1ns / 1ps

module tpa_dpath import tpa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [1:0]           in_cmd,
    input  logic [PAGE_BITS-1:0] in_page,
    output logic [PAGE_BITS-1:0] out_page,
    output logic [REF_BITS-1:0]  out_count,
    output logic [1:0]           out_status
);

    // storage
    logic [FC_W-1:0]     fc_mem [INNER];
    logic [REF_BITS-1:0] pr_mem [LEAVES];

    logic                 fc_we;
    logic [PAGE_BITS-1:0] fc_wa, fc_ra;
    logic [FC_W-1:0]      fc_wd, fc_rd_reg;
    logic                 pr_we;
    logic [PAGE_BITS-1:0] pr_wa, pr_ra;
    logic [REF_BITS-1:0]  pr_wd, pr_rd_reg;

    // registers
    logic [PAGE_BITS-1:0] clr_reg, clr_next;
    logic [FC_W-1:0]      under_reg, under_next;
    op_t                  op_reg, op_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [PAGE_BITS-1:0] node_reg, node_next;
    logic [FC_W-1:0]      cnt_reg, cnt_next;
    logic [PAGE_BITS-1:0] path_reg, path_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [PAGE_BITS-1:0] cur_reg, cur_next;
    logic [PAGE_BITS-1:0] res_page_reg, res_page_next;
    logic [REF_BITS-1:0]  res_cnt_reg, res_cnt_next;
    st_t                  res_st_reg, res_st_next;
    logic [PAGE_BITS-1:0] out_page_reg, out_page_next;
    logic [REF_BITS-1:0]  out_cnt_reg, out_cnt_next;
    st_t                  out_st_reg, out_st_next;

    // walk helpers
    logic                 dir_down, dir_leaf;
    logic [PAGE_BITS:0]   node_x2, path_x2, en_node_x, en_path_x;
    logic [PAGE_BITS-1:0] child_node, child_path;
    logic [PAGE_BITS-1:0] en_node, en_path, en_child, en_leaf, leaf_page;
    logic [FC_W-1:0]      en_cnt;
    logic [LVL_W-1:0]     en_lvl;
    logic                 en_bottom;
    logic [PAGE_BITS-1:0] anc_first, cur_m1, cur_par;
    logic [PAGE_BITS:0]   clr_p1, clr_p2;
    logic                 clr_done, clr_inner, clr_halve;

    always_comb begin
        dir_down   = (fc_rd_reg == '0);
        dir_leaf   = (pr_rd_reg != '0);
        node_x2    = {node_reg, 1'b0};
        path_x2    = {path_reg, 1'b0};
        child_node = (node_x2[PAGE_BITS-1:0] | PAGE_BITS'(1)) + PAGE_BITS'(dir_down);
        child_path = path_x2[PAGE_BITS-1:0] | PAGE_BITS'(dir_down);
        leaf_page  = path_x2[PAGE_BITS-1:0] | PAGE_BITS'(dir_leaf);

        if (cmd.down_first) begin
            en_node = '0;
            en_cnt  = fc_rd_reg;
            en_path = '0;
            en_lvl  = '0;
        end else begin
            en_node = child_node;
            en_cnt  = dir_down ? cnt_reg : fc_rd_reg;
            en_path = child_path;
            en_lvl  = lvl_reg + 1'b1;
        end
        en_bottom = (en_lvl == LVL_W'(BOTTOM));
        en_node_x = {en_node, 1'b1};
        en_path_x = {en_path, 1'b0};
        en_child  = en_node_x[PAGE_BITS-1:0];
        en_leaf   = en_path_x[PAGE_BITS-1:0];

        anc_first = PAGE_BITS'(HALF - 1) + (pg_reg >> 1);
        cur_m1    = cur_reg - 1'b1;
        cur_par   = cur_m1 >> 1;

        clr_done  = (clr_reg == '1);
        clr_inner = !clr_done;
        clr_p1    = {1'b0, clr_reg} + 1'b1;
        clr_p2    = {1'b0, clr_reg} + 2'd2;
        clr_halve = ((clr_p1 & clr_p2) == '0);
    end

    always_comb begin
        fc_we = 1'b0;
        fc_wa = '0;
        fc_wd = '0;
        fc_ra = '0;
        pr_we = 1'b0;
        pr_wa = pg_reg;
        pr_wd = '0;
        pr_ra = in_page;

        clr_next      = clr_reg;
        under_next    = under_reg;
        op_next       = op_reg;
        pg_next       = pg_reg;
        node_next     = node_reg;
        cnt_next      = cnt_reg;
        path_next     = path_reg;
        lvl_next      = lvl_reg;
        cur_next      = cur_reg;
        res_page_next = res_page_reg;
        res_cnt_next  = res_cnt_reg;
        res_st_next   = res_st_reg;
        out_page_next = out_page_reg;
        out_cnt_next  = out_cnt_reg;
        out_st_next   = out_st_reg;

        if (cmd.clear) begin
            pr_we = 1'b1;
            pr_wa = clr_reg;
            pr_wd = '0;
            fc_we = clr_inner;
            fc_wa = clr_reg;
            fc_wd = under_reg;
            if (!clr_done) begin
                clr_next = clr_reg + 1'b1;
            end
            if (clr_halve) begin
                under_next = under_reg >> 1;
            end
        end

        if (cmd.take) begin
            op_next = op_t'(in_cmd);
            pg_next = in_page;
        end

        // enter a node: take one free page from it and fetch its left child
        if (cmd.down_first || cmd.down_next) begin
            fc_we     = 1'b1;
            fc_wa     = en_node;
            fc_wd     = en_cnt - 1'b1;
            node_next = en_node;
            cnt_next  = en_cnt;
            path_next = en_path;
            lvl_next  = en_lvl;
            if (en_bottom) begin
                pr_ra = en_leaf;
            end else begin
                fc_ra = en_child;
            end
        end

        if (cmd.leaf) begin
            pr_we         = 1'b1;
            pr_wa         = leaf_page;
            pr_wd         = REF_BITS'(1);
            res_page_next = leaf_page;
            res_cnt_next  = REF_BITS'(1);
            res_st_next   = ST_OK;
        end

        if (cmd.res_full) begin
            res_page_next = '0;
            res_cnt_next  = '0;
            res_st_next   = ST_FULL;
        end

        if (cmd.res_unref) begin
            res_page_next = pg_reg;
            res_cnt_next  = '0;
            res_st_next   = ST_UNREF;
        end

        if (cmd.res_sat) begin
            res_page_next = pg_reg;
            res_cnt_next  = pr_rd_reg;
            res_st_next   = ST_SAT;
        end

        if (cmd.echo) begin
            res_page_next = pg_reg;
            res_cnt_next  = pr_rd_reg;
            res_st_next   = ST_OK;
        end

        if (cmd.add_inc) begin
            pr_we         = 1'b1;
            pr_wd         = pr_rd_reg + 1'b1;
            res_page_next = pg_reg;
            res_cnt_next  = pr_rd_reg + 1'b1;
            res_st_next   = ST_OK;
        end

        if (cmd.rel_dec) begin
            pr_we         = 1'b1;
            pr_wd         = pr_rd_reg - 1'b1;
            res_page_next = pg_reg;
            res_cnt_next  = pr_rd_reg - 1'b1;
            res_st_next   = ST_OK;
        end

        if (cmd.up_start) begin
            fc_ra    = anc_first;
            cur_next = anc_first;
        end

        // give back: bump this ancestor, fetch its parent
        if (cmd.up_step) begin
            fc_we    = 1'b1;
            fc_wa    = cur_reg;
            fc_wd    = fc_rd_reg + 1'b1;
            fc_ra    = cur_par;
            cur_next = cur_par;
        end

        if (cmd.load_out) begin
            out_page_next = res_page_reg;
            out_cnt_next  = res_cnt_reg;
            out_st_next   = res_st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fc_we) begin
            fc_mem[fc_wa] <= fc_wd;
        end
        fc_rd_reg <= fc_mem[fc_ra];
    end

    always_ff @(posedge aclk) begin
        if (pr_we) begin
            pr_mem[pr_wa] <= pr_wd;
        end
        pr_rd_reg <= pr_mem[pr_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            under_reg <= FC_W'(LEAVES);
        end else begin
            clr_reg   <= clr_next;
            under_reg <= under_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        pg_reg       <= pg_next;
        node_reg     <= node_next;
        cnt_reg      <= cnt_next;
        path_reg     <= path_next;
        lvl_reg      <= lvl_next;
        cur_reg      <= cur_next;
        res_page_reg <= res_page_next;
        res_cnt_reg  <= res_cnt_next;
        res_st_reg   <= res_st_next;
        out_page_reg <= out_page_next;
        out_cnt_reg  <= out_cnt_next;
        out_st_reg   <= out_st_next;
    end

    always_comb begin
        stat.op        = op_reg;
        stat.clr_done  = clr_done;
        stat.root_zero = (fc_rd_reg == '0);
        stat.ref_zero  = (pr_rd_reg == '0);
        stat.ref_max   = (pr_rd_reg == '1);
        stat.ref_one   = (pr_rd_reg == REF_BITS'(1));
        stat.en_bottom = en_bottom;
        stat.cur_root  = (cur_reg == '0);
    end

    assign out_page   = out_page_reg;
    assign out_count  = out_cnt_reg;
    assign out_status = out_st_reg;

endmodule
